// ----- design/fsrs_pkg.sv -----
// Shared widths, codes and types of the roulette selection engine.
`default_nettype none

package fsrs_pkg;

	localparam int POP_MAX_DEF = 64;

	localparam int FIT_W   = 32;
	localparam int ORG_W   = 6;
	localparam int RANK_W  = 6;
	localparam int FRAC_W  = 16;
	localparam int PSZ_W   = 7;
	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 2;
	localparam int TDI_W   = 48;
	localparam int TDO_W   = 80;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam func_t FUNC_LOAD   = 2'd0;
	localparam func_t FUNC_FINISH = 2'd1;
	localparam func_t FUNC_DRAW   = 2'd2;

	localparam kind_t KIND_LOAD    = 2'd0;
	localparam kind_t KIND_SUMMARY = 2'd1;
	localparam kind_t KIND_DRAW    = 2'd2;

	typedef struct packed {
		logic [ORG_W-1:0] origin;
		logic [FIT_W-1:0] fitness;
	} entry_t;

	localparam int ENTRY_W = ORG_W + FIT_W;

endpackage

`default_nettype wire

// ----- design/fitness_sort_roulette_select_top.sv -----
// Top level of the fitness-proportionate roulette selection engine.
//
// Requests enter on the s_ stream: s_tuser carries the function (load, finish, draw),
// s_tdata the fitness and the random fraction. Each load, finish or draw gives one
// result on the m_ stream; function code 3 is dropped with no result.
// pop_size is written on the cfg channel, taken only while the engine is idle.
// One request is worked at a time; s_tready is high only in the idle state.
// Work per request, n = effective population size:
//   load   : the entry goes into the sort RAM unless n entries are already held
//   finish : bubble sort through the sort RAM, then the running sums into the
//            cumulative RAM, then the bit-serial mean divider
//   draw   : scan of k ranks in the cumulative RAM (k <= n), then the origin read
// A finished result sits in the output register until taken; the next request
// is accepted meanwhile and its result waits in the engine until the output frees.
// Reset sets pop_size to 64, clears the load count and the total, and empties
// the output; the RAM contents are undefined until written.
`default_nettype none

module fitness_sort_roulette_select_top #(
	parameter int POP_MAX = fsrs_pkg::POP_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [fsrs_pkg::TDI_W-1:0]  s_tdata,  // fitness_value, rand_fraction
	input  wire logic [fsrs_pkg::FUNC_W-1:0] s_tuser,  // func
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [fsrs_pkg::TDO_W-1:0]  m_tdata,  // load_overflow, best_fitness,
	                                                   // mean_fitness, selected_rank,
	                                                   // selected_origin, zero fill
	output logic      [fsrs_pkg::KIND_W-1:0] m_tuser,  // result_kind
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [fsrs_pkg::PSZ_W-1:0]  cfg_data   // pop_size
);

	import fsrs_pkg::*;

	localparam int IDX_W  = $clog2(POP_MAX);
	localparam int CNT_W  = $clog2(POP_MAX + 1);
	localparam int CMP_W  = (CNT_W > PSZ_W) ? CNT_W : PSZ_W;
	localparam int CUM_W  = FIT_W + IDX_W;
	localparam int PROD_W = CUM_W + FRAC_W;
	localparam int DCNT_W = $clog2(CUM_W + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMIT,
		ST_PASS_RD,
		ST_PASS_LD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_PASS_END,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_DIV,
		ST_DRAW_RD,
		ST_DRAW_CMP,
		ST_ORG_RD,
		ST_ORG_WAIT
	} state_t;

	state_t              state_q;
	logic [PSZ_W-1:0]    pop_size_q;
	logic [CNT_W-1:0]    count_q;
	logic [CUM_W-1:0]    total_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    len_q;
	logic [CNT_W-1:0]    last_q;
	entry_t              carry_q;
	logic [CUM_W-1:0]    acc_q;
	logic [CUM_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    rem_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic [PROD_W-1:0]   target_q;
	logic [IDX_W-1:0]    rank_q;
	kind_t               res_kind_q;
	logic                res_ovf_q;
	logic [FIT_W-1:0]    res_best_q;
	logic [FIT_W-1:0]    res_mean_q;
	logic [ORG_W-1:0]    res_org_q;
	logic                m_tvalid_q;
	logic [TDO_W-1:0]    m_tdata_q;
	kind_t               m_tuser_q;

	logic [CMP_W-1:0]    psz_ext;
	logic [CNT_W-1:0]    n_eff;
	logic [CNT_W:0]      i_p1;
	logic [CNT_W:0]      i_p2;
	func_t               in_func;
	logic [FIT_W-1:0]    in_fit;
	logic [FRAC_W-1:0]   in_frac;
	logic                in_acc;
	logic                emit_go;

	logic                srt_we;
	logic [IDX_W-1:0]    srt_waddr;
	entry_t              srt_wdata;
	logic [IDX_W-1:0]    srt_raddr;
	logic [ENTRY_W-1:0]  srt_rdata;
	entry_t              srt_rd;
	logic                cum_we;
	logic [IDX_W-1:0]    cum_raddr;
	logic [CUM_W-1:0]    cum_rdata;

	logic                swap;
	logic [CUM_W-1:0]    sum_nxt;
	logic                hit;
	logic [CNT_W:0]      rem_sh;
	logic                q_bit;
	logic [CNT_W-1:0]    rem_nxt;
	logic [CUM_W-1:0]    dvd_nxt;

	assign in_func = s_tuser;
	assign in_fit  = s_tdata[FIT_W-1:0];
	assign in_frac = s_tdata[FIT_W +: FRAC_W];
	assign in_acc  = s_tvalid && s_tready;
	assign emit_go = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign psz_ext = CMP_W'(pop_size_q);

	always_comb begin
		if (pop_size_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (psz_ext > CMP_W'(POP_MAX)) begin
			n_eff = CNT_W'(POP_MAX);
		end else begin
			n_eff = CNT_W'(psz_ext);
		end
	end

	assign i_p1 = {1'b0, i_q} + (CNT_W+1)'(1);
	assign i_p2 = {1'b0, i_q} + (CNT_W+1)'(2);

	assign srt_rd  = entry_t'(srt_rdata);
	assign swap    = carry_q.fitness <= srt_rd.fitness;
	assign sum_nxt = acc_q + CUM_W'(srt_rd.fitness);
	assign hit     = {cum_rdata, {FRAC_W{1'b0}}} >= target_q;
	assign rem_sh  = {rem_q, dvd_q[CUM_W-1]};
	assign q_bit   = rem_sh >= {1'b0, n_eff};
	assign rem_nxt = q_bit ? CNT_W'(rem_sh - {1'b0, n_eff}) : CNT_W'(rem_sh);
	assign dvd_nxt = {dvd_q[CUM_W-2:0], q_bit};

	always_comb begin
		srt_we    = 1'b0;
		srt_waddr = i_q[IDX_W-1:0];
		srt_wdata = carry_q;
		srt_raddr = '0;
		cum_we    = 1'b0;
		cum_raddr = i_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				srt_we    = in_acc && (in_func == FUNC_LOAD) && (count_q < n_eff);
				srt_waddr = count_q[IDX_W-1:0];
				srt_wdata = '{origin: ORG_W'(count_q), fitness: in_fit};
			end
			ST_SORT_RD: begin
				srt_raddr = i_p1[IDX_W-1:0];
			end
			ST_SORT_CMP: begin
				srt_we    = 1'b1;
				srt_wdata = swap ? srt_rd : carry_q;
			end
			ST_PASS_END: begin
				srt_we = 1'b1;
			end
			ST_SUM_RD: begin
				srt_raddr = i_q[IDX_W-1:0];
			end
			ST_SUM_ACC: begin
				cum_we = 1'b1;
			end
			ST_ORG_RD: begin
				srt_raddr = rank_q;
			end
			ST_EMIT, ST_PASS_RD, ST_PASS_LD, ST_DIV, ST_DRAW_RD, ST_DRAW_CMP,
			ST_ORG_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	fsrs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(POP_MAX)
	) u_sort_ram (
		.clk  (clk),
		.we   (srt_we),
		.waddr(srt_waddr),
		.wdata(srt_wdata),
		.raddr(srt_raddr),
		.rdata(srt_rdata)
	);

	fsrs_ram #(
		.WIDTH(CUM_W),
		.DEPTH(POP_MAX)
	) u_cum_ram (
		.clk  (clk),
		.we   (cum_we),
		.waddr(i_q[IDX_W-1:0]),
		.wdata(sum_nxt),
		.raddr(cum_raddr),
		.rdata(cum_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pop_size_q <= PSZ_W'(64);
			count_q    <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
			i_q        <= '0;
			len_q      <= '0;
			last_q     <= '0;
			dcnt_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pop_size_q <= cfg_data;
			end
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_ovf_q  <= (in_func == FUNC_LOAD) && !(count_q < n_eff);
						res_best_q <= '0;
						res_mean_q <= '0;
						res_org_q  <= '0;
						rank_q     <= ((in_func == FUNC_DRAW) && (total_q == '0))
							? IDX_W'(n_eff - CNT_W'(1)) : '0;
						case (in_func)
							FUNC_LOAD: begin
								res_kind_q <= KIND_LOAD;
								if (count_q < n_eff) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_EMIT;
							end
							FUNC_FINISH: begin
								res_kind_q <= KIND_SUMMARY;
								len_q      <= n_eff;
								i_q        <= '0;
								acc_q      <= '0;
								state_q    <= (n_eff > CNT_W'(1)) ? ST_PASS_RD : ST_SUM_RD;
							end
							FUNC_DRAW: begin
								res_kind_q <= KIND_DRAW;
								i_q        <= '0;
								target_q   <= PROD_W'(in_frac) * PROD_W'(total_q);
								if (total_q == '0) begin
									state_q <= ST_ORG_RD;
								end else begin
									state_q <= ST_DRAW_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PASS_RD: begin
					i_q     <= '0;
					last_q  <= '0;
					state_q <= ST_PASS_LD;
				end
				ST_PASS_LD: begin
					carry_q <= srt_rd;
					state_q <= ST_SORT_RD;
				end
				ST_SORT_RD: begin
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (swap) begin
						last_q <= CNT_W'(i_p1);
					end else begin
						carry_q <= srt_rd;
					end
					i_q     <= CNT_W'(i_p1);
					state_q <= (i_p2 < {1'b0, len_q}) ? ST_SORT_RD : ST_PASS_END;
				end
				ST_PASS_END: begin
					len_q <= last_q;
					i_q   <= '0;
					if (last_q > CNT_W'(1)) begin
						state_q <= ST_PASS_RD;
					end else begin
						acc_q   <= '0;
						state_q <= ST_SUM_RD;
					end
				end
				ST_SUM_RD: begin
					state_q <= ST_SUM_ACC;
				end
				ST_SUM_ACC: begin
					acc_q <= sum_nxt;
					if (i_q == '0) begin
						res_best_q <= srt_rd.fitness;
					end
					i_q <= CNT_W'(i_p1);
					if (i_p1 < {1'b0, n_eff}) begin
						state_q <= ST_SUM_RD;
					end else begin
						total_q <= sum_nxt;
						count_q <= '0;
						dvd_q   <= sum_nxt;
						rem_q   <= '0;
						dcnt_q  <= DCNT_W'(CUM_W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dvd_q  <= dvd_nxt;
					rem_q  <= rem_nxt;
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == DCNT_W'(1)) begin
						res_mean_q <= dvd_nxt[FIT_W-1:0];
						state_q    <= ST_EMIT;
					end
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_CMP;
				end
				ST_DRAW_CMP: begin
					if (hit || !(i_p1 < {1'b0, n_eff})) begin
						rank_q  <= i_q[IDX_W-1:0];
						state_q <= ST_ORG_RD;
					end else begin
						i_q     <= CNT_W'(i_p1);
						state_q <= ST_DRAW_RD;
					end
				end
				ST_ORG_RD: begin
					state_q <= ST_ORG_WAIT;
				end
				ST_ORG_WAIT: begin
					res_org_q <= srt_rd.origin;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						m_tuser_q  <= res_kind_q;
						m_tdata_q  <= {3'b000, res_org_q,
							(res_kind_q == KIND_DRAW) ? RANK_W'(rank_q) : RANK_W'(0),
							res_mean_q, res_best_q, res_ovf_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ovf_on_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tuser == KIND_LOAD))
		else $error("overflow flag on a non-load result");

	a_rank_zero_off_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != KIND_DRAW)) |-> (m_tdata[76:65] == '0))
		else $error("selection fields set on a non-draw result");

	a_sort_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SORT_RD) || (state_q == ST_SORT_CMP))
		|-> ((i_p1 < {1'b0, len_q}) && (len_q <= n_eff)))
		else $error("bubble pass index beyond pass length");

	a_draw_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_CMP) |-> (i_q < n_eff))
		else $error("draw scan beyond population");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(POP_MAX)))
		else $error("load count beyond store depth");

endmodule

`default_nettype wire

// ----- design/fsrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fsrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
